// File: hdl/tmt_pkg.sv
// Shared types, constants and command codes of the TinyMT32 generator.
package tmt_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ROUND_W = 3;

  localparam logic [WORD_W-1:0] MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MAT1 = 32'h8f70_11ee;
  localparam logic [WORD_W-1:0] MAT2 = 32'hfc78_ff1f;
  localparam logic [WORD_W-1:0] TMAT = 32'h3793_fdff;
  localparam logic [WORD_W-1:0] MULT = 32'd1812433253;

  // Seed rounds run 1 to LAST_ROUND, then PRE_LOOP advances.
  localparam logic [ROUND_W-1:0] LAST_ROUND = 3'd7;
  localparam logic [COUNT_W-1:0] PRE_LOOP   = 17'd8;

  // Input action codes.
  localparam logic [1:0] ACT_SEED    = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  // Datapath state operations.
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_LOAD  = 3'd2;
  localparam logic [2:0] OP_ROUND = 3'd3;
  localparam logic [2:0] OP_ADV   = 3'd4;

  typedef logic [3:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [ROUND_W-1:0] round;
    logic               take_input;
    logic               capture_word;
    logic               load_out;
  } cmd_t;

endpackage

// File: hdl/tmt_datapath.sv
// TinyMT32 datapath: state words, seed rounds, advance, tempering and scaling.
module tmt_datapath (
  input  logic                           clk,
  input  tmt_pkg::cmd_t                  cmd,
  input  logic [tmt_pkg::WORD_W-1:0]     seed,
  input  logic [tmt_pkg::WORD_W-1:0]     state_word0,
  input  logic [tmt_pkg::WORD_W-1:0]     state_word1,
  input  logic [tmt_pkg::WORD_W-1:0]     state_word2,
  input  logic [tmt_pkg::WORD_W-1:0]     state_word3,
  input  logic [tmt_pkg::WORD_W-1:0]     range_max,
  input  logic                           rst,
  output logic [tmt_pkg::WORD_W-1:0]     random_word,
  output logic [tmt_pkg::WORD_W-1:0]     ranged_value
);

  function automatic tmt_pkg::state_t advance_once(input tmt_pkg::state_t s);
    logic [31:0] x;
    logic [31:0] y;
    tmt_pkg::state_t r;
    y = s[3];
    x = (s[0] & tmt_pkg::MASK) ^ s[1] ^ s[2];
    x = x ^ {x[30:0], 1'b0};
    y = y ^ {1'b0, y[31:1]} ^ x;
    r[0] = s[1];
    r[1] = s[2];
    r[2] = x ^ {y[21:0], 10'd0};
    r[3] = y;
    if (y[0]) begin
      r[1] = r[1] ^ tmt_pkg::MAT1;
      r[2] = r[2] ^ tmt_pkg::MAT2;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(input tmt_pkg::state_t s);
    logic [31:0] t0;
    logic [31:0] t1;
    t1 = s[0] + {8'd0, s[2][31:8]};
    t0 = s[3] ^ t1;
    if (t1[0]) begin
      t0 = t0 ^ tmt_pkg::TMAT;
    end
    return t0;
  endfunction

  tmt_pkg::state_t st;
  tmt_pkg::state_t st_next;
  logic [31:0] word;
  logic [31:0] range_r;
  logic [31:0] prev;
  logic [31:0] prev_mix;
  logic [63:0] mix_full;
  logic [31:0] mix;
  logic [63:0] product;

  // Previous word of the seed round: index (round - 1) mod 4.
  always_comb begin
    case (cmd.round[1:0])
      2'd0:    prev = st[3];
      2'd1:    prev = st[0];
      2'd2:    prev = st[1];
      2'd3:    prev = st[2];
      default: prev = st[0];
    endcase
  end

  assign prev_mix = prev ^ {30'd0, prev[31:30]};
  assign mix_full = {32'd0, tmt_pkg::MULT} * {32'd0, prev_mix};
  assign mix      = mix_full[31:0] + {{(32 - tmt_pkg::ROUND_W){1'b0}}, cmd.round};

  always_comb begin
    st_next = st;
    case (cmd.op)
      tmt_pkg::OP_INIT: begin
        st_next[0] = seed;
        st_next[1] = tmt_pkg::MAT1;
        st_next[2] = tmt_pkg::MAT2;
        st_next[3] = tmt_pkg::TMAT;
      end
      tmt_pkg::OP_LOAD: begin
        st_next[0] = state_word0;
        st_next[1] = state_word1;
        st_next[2] = state_word2;
        st_next[3] = state_word3;
      end
      tmt_pkg::OP_ROUND: begin
        for (int k = 0; k < 4; k++) begin
          if (cmd.round[1:0] == 2'(k)) begin
            st_next[k] = st[k] ^ mix;
          end
        end
      end
      tmt_pkg::OP_ADV: st_next = advance_once(st);
      default: st_next = st;
    endcase
  end

  assign product = {32'd0, word} * {32'd0, range_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_input) begin
      range_r <= range_max;
    end
    if (cmd.capture_word) begin
      word <= temper(st_next);
    end
    if (cmd.load_out) begin
      random_word  <= word;
      ranged_value <= product[63:32];
    end
  end

endmodule

// File: hdl/tmt_ctrl.sv
// TinyMT32 controller: action sequencing, round and advance counting, handshakes.
module tmt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    action,
  input  logic [tmt_pkg::COUNT_W-1:0]   advance_count,
  input  logic                          out_ready,
  output logic                          in_ready,
  output logic                          out_valid,
  output tmt_pkg::cmd_t                 cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEED = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [tmt_pkg::COUNT_W-1:0] cnt;
  logic [tmt_pkg::COUNT_W-1:0] cnt_next;
  logic                        load_out;
  logic                        accept;

  assign load_out = (state == S_MUL) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || load_out;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    cmd.op           = tmt_pkg::OP_HOLD;
    cmd.round        = cnt[tmt_pkg::ROUND_W-1:0];
    cmd.take_input   = accept;
    cmd.capture_word = 1'b0;
    cmd.load_out     = load_out;

    if (accept) begin
      case (action)
        tmt_pkg::ACT_SEED: begin
          cmd.op     = tmt_pkg::OP_INIT;
          cnt_next   = tmt_pkg::COUNT_W'(1);
          state_next = S_SEED;
        end
        tmt_pkg::ACT_LOAD: begin
          cmd.op           = tmt_pkg::OP_LOAD;
          cmd.capture_word = 1'b1;
          state_next       = S_MUL;
        end
        tmt_pkg::ACT_ADVANCE: begin
          if (advance_count == '0) begin
            cmd.capture_word = 1'b1;
            state_next       = S_MUL;
          end else begin
            cnt_next   = advance_count;
            state_next = S_ADV;
          end
        end
        default: begin
          cmd.capture_word = 1'b1;
          state_next       = S_MUL;
        end
      endcase
    end else begin
      case (state)
        S_SEED: begin
          cmd.op = tmt_pkg::OP_ROUND;
          if (cnt[tmt_pkg::ROUND_W-1:0] == tmt_pkg::LAST_ROUND) begin
            cnt_next   = tmt_pkg::PRE_LOOP;
            state_next = S_ADV;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
        S_ADV: begin
          cmd.op   = tmt_pkg::OP_ADV;
          cnt_next = cnt - 1'b1;
          if (cnt == tmt_pkg::COUNT_W'(1)) begin
            cmd.capture_word = 1'b1;
            state_next       = S_MUL;
          end
        end
        S_MUL: begin
          if (load_out) begin
            state_next = S_IDLE;
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/tinymt32_generator.sv
// Top level of the TinyMT32 generator: controller plus datapath.
//
// TinyMT32 pseudo-random generator with a 128-bit state that is all zero after
// reset. Each input transaction carries an action: seed (action 0) runs the
// standard seven multiply rounds, one round per cycle on a single 32x32
// multiplier, then eight state advances; load (action 1) writes the four state
// words; advance (action 2) steps the state advance_count times, one advance
// per cycle (a count of zero leaves the state alone); action 3 changes
// nothing. Every transaction returns one output transaction with the tempered
// word of the resulting state and (random_word * range_max) >> 32.
// The single-advance state loop and the seed multiply loop bound how fast
// transactions complete. The tempered word of the final state is captured in
// a word register with the last state update; the output register then takes
// that held word and the 64-bit product formed from it once the output is free.
// The next transaction is taken in the same cycle a finished result moves into
// the output register, as long as the previous result leaves that register in
// the same cycle; while a result waits with out_ready low, the input stalls.
module tinymt32_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] seed,
  input  logic [31:0] state_word0,
  input  logic [31:0] state_word1,
  input  logic [31:0] state_word2,
  input  logic [31:0] state_word3,
  input  logic [16:0] advance_count,
  input  logic [31:0] range_max,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  output logic [31:0] ranged_value
);

  // Command bundle from the sequencer to the datapath.
  tmt_pkg::cmd_t cmd;

  // Sequence the action and own both handshakes.
  tmt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .action        (action),
    .advance_count (advance_count),
    .out_ready     (out_ready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  // Hold the generator state and compute the result words.
  tmt_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .seed         (seed),
    .state_word0  (state_word0),
    .state_word1  (state_word1),
    .state_word2  (state_word2),
    .state_word3  (state_word3),
    .range_max    (range_max),
    .rst          (rst),
    .random_word  (random_word),
    .ranged_value (ranged_value)
  );

endmodule

// File: tb/tinymt32_generator_tb.sv
// Self-checking testbench for the TinyMT32 generator: directed table, then random traffic.
module tinymt32_generator_tb;

  // Action 3 has no name in the package; the block treats it as "leave the state alone".
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int DIRECTED_ROWS = 21;
  localparam int RANDOM_ITEMS  = 1530;
  localparam int REPORT_LIMIT  = 10;
  // The slowest legal run is dominated by the two long advances in the directed table
  // plus random traffic with every stall at its longest; take that several times over.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // After the last result: long enough for any stray extra result to show up.
  localparam int DRAIN_CYCLES  = 40;

  // Receiver stall modes.
  localparam int RX_STEADY = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_BURSTY = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seed;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [16:0] advance_count;
    logic [31:0] range_max;
  } gen_request_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] ranged;
  } gen_result_t;

  typedef struct packed {
    gen_request_t req;
    logic         known;  // expected result typed into the table
    gen_result_t  res;
  } table_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] seed;
  logic [31:0] state_word0;
  logic [31:0] state_word1;
  logic [31:0] state_word2;
  logic [31:0] state_word3;
  logic [16:0] advance_count;
  logic [31:0] range_max;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] random_word;
  logic [31:0] ranged_value;

  // Predicted generator state, kept in step with every accepted transaction.
  logic [31:0] prng_state [4];
  gen_result_t expected_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left;

  tinymt32_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .seed         (seed),
    .state_word0  (state_word0),
    .state_word1  (state_word1),
    .state_word2  (state_word2),
    .state_word3  (state_word3),
    .advance_count(advance_count),
    .range_max    (range_max),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_word  (random_word),
    .ranged_value (ranged_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One step of the 127-bit linear recurrence.
  function automatic void prng_advance();
    logic [31:0] x;
    logic [31:0] y;
    y = prng_state[3];
    x = (prng_state[0] & tmt_pkg::MASK) ^ prng_state[1] ^ prng_state[2];
    x ^= x << 1;
    y ^= (y >> 1) ^ x;
    prng_state[0] = prng_state[1];
    prng_state[1] = prng_state[2];
    prng_state[2] = x ^ (y << 10);
    prng_state[3] = y;
    if (y[0]) begin
      prng_state[1] ^= tmt_pkg::MAT1;
      prng_state[2] ^= tmt_pkg::MAT2;
    end
  endfunction

  // Multiply rounds over the four words, then the pre-loop advances.
  function automatic void prng_seed(input logic [31:0] s);
    logic [31:0] prev;
    logic [31:0] round_idx;
    prng_state[0] = s;
    prng_state[1] = tmt_pkg::MAT1;
    prng_state[2] = tmt_pkg::MAT2;
    prng_state[3] = tmt_pkg::TMAT;
    for (int i = 1; i <= int'(tmt_pkg::LAST_ROUND); i++) begin
      round_idx = i;
      prev = prng_state[(i - 1) % 4];
      prng_state[i % 4] ^= round_idx + tmt_pkg::MULT * (prev ^ (prev >> 30));
    end
    for (int i = 0; i < int'(tmt_pkg::PRE_LOOP); i++) prng_advance();
  endfunction

  function automatic logic [31:0] prng_temper();
    logic [31:0] t0;
    logic [31:0] t1;
    t0 = prng_state[3];
    t1 = prng_state[0] + (prng_state[2] >> 8);
    t0 ^= t1;
    if (t1[0]) t0 ^= tmt_pkg::TMAT;
    return t0;
  endfunction

  // Apply one request to the predicted state and form the result it returns.
  function automatic gen_result_t predict_result(input gen_request_t req);
    gen_result_t res;
    logic [63:0] product;
    case (req.action)
      tmt_pkg::ACT_SEED: prng_seed(req.seed);
      tmt_pkg::ACT_LOAD: begin
        prng_state[0] = req.word0;
        prng_state[1] = req.word1;
        prng_state[2] = req.word2;
        prng_state[3] = req.word3;
      end
      tmt_pkg::ACT_ADVANCE: begin
        for (int n = 0; n < int'(req.advance_count); n++) prng_advance();
      end
      default: ;
    endcase
    res.word   = prng_temper();
    product    = {32'd0, res.word} * {32'd0, req.range_max};
    res.ranged = product[63:32];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic table_row_t stim_row(input logic [1:0] act, input logic [31:0] sd,
                                          input logic [31:0] w0, input logic [31:0] w1,
                                          input logic [31:0] w2, input logic [31:0] w3,
                                          input logic [16:0] cnt, input logic [31:0] rmax,
                                          input logic known, input logic [31:0] kword,
                                          input logic [31:0] kranged);
    table_row_t row;
    row.req.action        = act;
    row.req.seed          = sd;
    row.req.word0         = w0;
    row.req.word1         = w1;
    row.req.word2         = w2;
    row.req.word3         = w3;
    row.req.advance_count = cnt;
    row.req.range_max     = rmax;
    row.known             = known;
    row.res.word          = kword;
    row.res.ranged        = kranged;
    return row;
  endfunction

  // Directed table. Known results follow from the zero state after reset, or from a load
  // with words 0 and 2 cleared, where the tempered word is simply word 3.
  function automatic table_row_t directed_row(input int idx);
    case (idx)
      // unused action on the unseeded zero state
      0:  return stim_row(ACT_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'hffff_ffff, 1'b1, 32'h0, 32'h0);
      // zero advance count, then a short advance: the zero state stays zero
      1:  return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0,
                          32'hffff_ffff, 1'b1, 32'h0, 32'h0);
      2:  return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd5,
                          32'd12345, 1'b1, 32'h0, 32'h0);
      // largest word times largest range
      3:  return stim_row(tmt_pkg::ACT_LOAD, 32'h0, 32'h0, 32'h1234_5678, 32'h0,
                          32'hffff_ffff, 17'h0, 32'hffff_ffff, 1'b1, 32'hffff_ffff,
                          32'hffff_fffe);
      // unused action keeps the loaded state; zero range gives zero
      4:  return stim_row(ACT_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'h0, 1'b1, 32'hffff_ffff, 32'h0);
      5:  return stim_row(tmt_pkg::ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 17'h0,
                          32'd2, 1'b1, 32'h8000_0000, 32'd1);
      // seed extremes
      6:  return stim_row(tmt_pkg::ACT_SEED, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'hffff_ffff, 1'b0, 32'h0, 32'h0);
      7:  return stim_row(tmt_pkg::ACT_SEED, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'd1, 1'b0, 32'h0, 32'h0);
      8:  return stim_row(tmt_pkg::ACT_SEED, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'd100, 1'b0, 32'h0, 32'h0);
      9:  return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd1,
                          32'h0, 1'b0, 32'h0, 32'h0);
      10: return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0,
                          32'd6, 1'b0, 32'h0, 32'h0);
      // unused action with every other field busy: all of it must be ignored
      11: return stim_row(ACT_NONE, 32'hdead_beef, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                          32'h0, 17'h1_ffff, 32'h7fff_ffff, 1'b0, 32'h0, 32'h0);
      12: return stim_row(tmt_pkg::ACT_LOAD, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 17'h0, 32'hffff_ffff, 1'b0,
                          32'h0, 32'h0);
      // full 17-bit advance count
      13: return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                          17'h1_ffff, 32'h8000_0000, 1'b0, 32'h0, 32'h0);
      14: return stim_row(tmt_pkg::ACT_SEED, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0,
                          17'h1_0000, 32'd1000, 1'b0, 32'h0, 32'h0);
      // just past 16 bits of count
      15: return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                          17'h1_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0);
      16: return stim_row(tmt_pkg::ACT_LOAD, 32'h0, 32'haaaa_aaaa, 32'h5555_5555,
                          32'haaaa_aaaa, 32'h5555_5555, 17'h0, 32'd3, 1'b0, 32'h0, 32'h0);
      17: return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd3,
                          32'hffff_ffff, 1'b0, 32'h0, 32'h0);
      18: return stim_row(tmt_pkg::ACT_SEED, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                          17'h0, 32'h8000_0000, 1'b0, 32'h0, 32'h0);
      // back to the all-zero state, which no advance can leave
      19: return stim_row(tmt_pkg::ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0,
                          32'd7, 1'b1, 32'h0, 32'h0);
      20: return stim_row(tmt_pkg::ACT_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd100,
                          32'hffff_ffff, 1'b1, 32'h0, 32'h0);
      default: return '0;
    endcase
  endfunction

  // Random request: mostly short advances between seeds and loads, unused fields noisy.
  function automatic gen_request_t random_request();
    gen_request_t req;
    int pick;
    req.seed          = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom;
    req.word0         = $urandom;
    req.word1         = $urandom;
    req.word2         = $urandom;
    req.word3         = $urandom;
    req.advance_count = 17'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25)      req.action = tmt_pkg::ACT_SEED;
    else if (pick < 45) req.action = tmt_pkg::ACT_LOAD;
    else if (pick < 90) req.action = tmt_pkg::ACT_ADVANCE;
    else                req.action = ACT_NONE;
    // now and then load the all-zero state
    if (req.action == tmt_pkg::ACT_LOAD && $urandom_range(0, 19) == 0) begin
      req.word0 = '0;
      req.word1 = '0;
      req.word2 = '0;
      req.word3 = '0;
    end
    // keep advance counts short on the whole; the long ones live in the directed table
    if (req.action == tmt_pkg::ACT_ADVANCE) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      req.advance_count = 17'($urandom_range(0, 8));
      else if (pick < 90) req.advance_count = 17'($urandom_range(0, 63));
      else if (pick < 99) req.advance_count = 17'($urandom_range(0, 511));
      else                req.advance_count = 17'($urandom_range(0, 4095));
    end
    pick = $urandom_range(0, 99);
    if (pick < 10)      req.range_max = '0;
    else if (pick < 20) req.range_max = 32'hffff_ffff;
    else if (pick < 40) req.range_max = $urandom_range(1, 1000);
    else                req.range_max = $urandom;
    return req;
  endfunction

  // Present one transaction from a falling edge, hold it until accepted, and record
  // what it must return. Returns on the falling edge after acceptance.
  task automatic offer_request(input gen_request_t req, input logic known,
                               input gen_result_t known_res);
    gen_result_t predicted;
    gen_result_t expected;
    in_valid      <= 1'b1;
    action        <= req.action;
    seed          <= req.seed;
    state_word0   <= req.word0;
    state_word1   <= req.word1;
    state_word2   <= req.word2;
    state_word3   <= req.word3;
    advance_count <= req.advance_count;
    range_max     <= req.range_max;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // run the predictor even for typed-in rows so its state follows the block
    predicted = predict_result(req);
    expected  = known ? known_res : predicted;
    expected_results = {expected_results, expected};
    @(negedge clk);
  endtask

  // Bursts of random length with random gaps; some bursts are back to back.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    table_row_t  row;
    gen_result_t no_result;
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = '0;
    seed          = '0;
    state_word0   = '0;
    state_word1   = '0;
    state_word2   = '0;
    state_word3   = '0;
    advance_count = '0;
    range_max     = '0;
    no_result     = '0;
    burst_left    = 0;
    for (int i = 0; i < 4; i++) prng_state[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_row(i);
      offer_request(row.req, row.known, row.res);
      pace_sender();
    end
    wait_for_drain();

    // pause once more halfway through so the block runs completely dry mid-stream
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      offer_request(random_request(), 1'b0, no_result);
      pace_sender();
    end
    wait_for_drain();

    // give a stray extra result time to appear
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that switches between steady, random and bursty modes
  // ---------------------------------------------------------------------------

  initial begin
    int rx_mode;
    int mode_left;
    int stall_left;
    out_ready  = 1'b0;
    rx_mode    = RX_STEADY;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(RX_STEADY, RX_BURSTY);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // take one transaction, then stall for a random stretch
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready  <= 1'b1;
            stall_left = $urandom_range(0, 15);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    gen_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result: random_word %h ranged_value %h",
                   random_word, ranged_value);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (random_word !== want.word || ranged_value !== want.ranged) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: random_word exp %h got %h, ranged_value exp %h got %h",
                     want.word, random_word, want.ranged, ranged_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
